### design/shb_pkg.sv
// ----------------------------------------------------------------------------
// shb_pkg
// Shared types and constants for the speed histogram binner: field widths,
// command and register codes, the configuration struct and the state types.
// ----------------------------------------------------------------------------
`default_nettype none

package shb_pkg;

  localparam int SPEED_W = 24;
  localparam int NBIN_W  = 7;
  localparam int COUNT_W = 32;
  localparam int SEL_W   = 6;
  localparam int MODE_W  = 2;
  localparam int ALU_W   = 32;
  localparam int STEP_W  = 3;

  // Command codes carried on the mode port.
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // Register indexes (word address on the configuration port).
  localparam logic [1:0] REG_RANGE_MIN   = 2'd0;
  localparam logic [1:0] REG_RANGE_MAX   = 2'd1;
  localparam logic [1:0] REG_BINS_IN_USE = 2'd2;

  localparam logic [SPEED_W-1:0] RANGE_MIN_RST   = 24'd0;
  localparam logic [SPEED_W-1:0] RANGE_MAX_RST   = 24'd11520;
  localparam logic [NBIN_W-1:0]  BINS_IN_USE_RST = 7'd20;

  typedef struct packed {
    logic [SPEED_W-1:0] range_min;
    logic [SPEED_W-1:0] range_max;
    logic [NBIN_W-1:0]  bins_in_use;
  } cfg_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_BIN,
    S_INC,
    S_RDOUT
  } state_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_DEN,
    C_DIFF,
    C_CMP,
    C_MUL,
    C_DIV,
    C_DONE
  } calc_state_t;

endpackage

`default_nettype wire

### design/shb_cfg.sv
// ----------------------------------------------------------------------------
// shb_cfg
// APB-style register file holding the histogram range and the bin count.
// ----------------------------------------------------------------------------
`default_nettype none

module shb_cfg (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  output shb_pkg::cfg_t            cfg
);

  logic       wr_en;
  logic [1:0] index;

  assign pready = 1'b1;
  assign index  = paddr[3:2];
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.range_min   <= shb_pkg::RANGE_MIN_RST;
      cfg.range_max   <= shb_pkg::RANGE_MAX_RST;
      cfg.bins_in_use <= shb_pkg::BINS_IN_USE_RST;
    end else if (wr_en) begin
      unique case (index)
        shb_pkg::REG_RANGE_MIN:   cfg.range_min   <= pwdata[shb_pkg::SPEED_W-1:0];
        shb_pkg::REG_RANGE_MAX:   cfg.range_max   <= pwdata[shb_pkg::SPEED_W-1:0];
        shb_pkg::REG_BINS_IN_USE: cfg.bins_in_use <= pwdata[shb_pkg::NBIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      shb_pkg::REG_RANGE_MIN:   prdata = 32'(cfg.range_min);
      shb_pkg::REG_RANGE_MAX:   prdata = 32'(cfg.range_max);
      shb_pkg::REG_BINS_IN_USE: prdata = 32'(cfg.bins_in_use);
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

### design/shb_bin_calc.sv
// ----------------------------------------------------------------------------
// shb_bin_calc
// Bin index engine. One shared 32-bit add/subtract unit computes the range
// width, the offset, the overflow check, a shift-add multiply by the bin
// count and a restoring divide by the range width, one step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module shb_bin_calc (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [shb_pkg::SPEED_W-1:0]   speed,
  input  wire logic [shb_pkg::SPEED_W-1:0]   range_min,
  input  wire logic [shb_pkg::SPEED_W-1:0]   range_max,
  input  wire logic [shb_pkg::NBIN_W-1:0]    nbins,
  output logic                               done,
  output logic [shb_pkg::NBIN_W-1:0]         bin
);

  localparam logic [shb_pkg::STEP_W-1:0] LAST_STEP = 3'(shb_pkg::NBIN_W - 1);

  shb_pkg::calc_state_t state, state_next;

  logic [shb_pkg::SPEED_W-1:0] speed_q;
  logic [shb_pkg::SPEED_W-1:0] den;
  logic [shb_pkg::SPEED_W-1:0] diff;
  logic                        empty;
  logic [shb_pkg::ALU_W-1:0]   acc;
  logic [shb_pkg::ALU_W-1:0]   mcand;
  logic [shb_pkg::ALU_W-1:0]   dsh;
  logic [shb_pkg::NBIN_W-1:0]  nsh;
  logic [shb_pkg::NBIN_W-1:0]  q;
  logic [shb_pkg::STEP_W-1:0]  cnt;
  logic [shb_pkg::NBIN_W-1:0]  last_bin;

  // Shared add/subtract unit.
  logic [shb_pkg::ALU_W-1:0] op_a, op_b;
  logic                      op_sub;
  logic [shb_pkg::ALU_W:0]   sum;
  logic                      borrow;

  assign sum = {1'b0, op_a} + {1'b0, (op_sub ? ~op_b : op_b)}
             + (shb_pkg::ALU_W+1)'(op_sub);
  assign borrow   = op_sub & ~sum[shb_pkg::ALU_W];
  assign last_bin = nbins - 7'd1;
  assign done     = (state == shb_pkg::C_DONE);
  assign bin      = q;

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sub = 1'b1;
    unique case (state)
      shb_pkg::C_DEN: begin
        op_a = 32'(range_max);
        op_b = 32'(range_min);
      end
      shb_pkg::C_DIFF: begin
        op_a = 32'(speed_q);
        op_b = 32'(range_min);
      end
      shb_pkg::C_CMP: begin
        op_a = 32'(diff);
        op_b = 32'(den);
      end
      shb_pkg::C_MUL: begin
        op_a   = acc;
        op_b   = mcand;
        op_sub = 1'b0;
      end
      shb_pkg::C_DIV: begin
        op_a = acc;
        op_b = dsh;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      shb_pkg::C_IDLE: if (start) state_next = shb_pkg::C_DEN;
      shb_pkg::C_DEN:  state_next = shb_pkg::C_DIFF;
      shb_pkg::C_DIFF: begin
        if (empty || borrow) state_next = shb_pkg::C_DONE;
        else state_next = shb_pkg::C_CMP;
      end
      shb_pkg::C_CMP: begin
        if (!borrow) state_next = shb_pkg::C_DONE;
        else state_next = shb_pkg::C_MUL;
      end
      shb_pkg::C_MUL:  if (cnt == LAST_STEP) state_next = shb_pkg::C_DIV;
      shb_pkg::C_DIV:  if (cnt == LAST_STEP) state_next = shb_pkg::C_DONE;
      shb_pkg::C_DONE: state_next = shb_pkg::C_IDLE;
      default:         state_next = shb_pkg::C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= shb_pkg::C_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      shb_pkg::C_IDLE: begin
        if (start) speed_q <= speed;
      end
      shb_pkg::C_DEN: begin
        den   <= sum[shb_pkg::SPEED_W-1:0];
        empty <= borrow | (sum[shb_pkg::SPEED_W-1:0] == '0);
      end
      shb_pkg::C_DIFF: begin
        diff <= sum[shb_pkg::SPEED_W-1:0];
        if (empty) q <= last_bin;
        else if (borrow) q <= '0;
      end
      shb_pkg::C_CMP: begin
        // An offset at or past the range width lands in the overflow bin.
        if (!borrow) q <= last_bin;
        acc   <= '0;
        mcand <= 32'(diff);
        nsh   <= nbins;
        cnt   <= '0;
      end
      shb_pkg::C_MUL: begin
        if (nsh[0]) acc <= sum[shb_pkg::ALU_W-1:0];
        mcand <= {mcand[shb_pkg::ALU_W-2:0], 1'b0};
        nsh   <= {1'b0, nsh[shb_pkg::NBIN_W-1:1]};
        if (cnt == LAST_STEP) begin
          cnt <= '0;
          dsh <= 32'({den, {(shb_pkg::NBIN_W-1){1'b0}}});
          q   <= '0;
        end else begin
          cnt <= cnt + 3'd1;
        end
      end
      shb_pkg::C_DIV: begin
        // The quotient is known to be below the bin count, so seven steps do.
        if (!borrow) acc <= sum[shb_pkg::ALU_W-1:0];
        q   <= {q[shb_pkg::NBIN_W-2:0], ~borrow};
        dsh <= {1'b0, dsh[shb_pkg::ALU_W-1:1]};
        cnt <= cnt + 3'd1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### design/shb_mem.sv
// ----------------------------------------------------------------------------
// shb_mem
// Bin counter store: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module shb_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [AW-1:0]                 waddr,
  input  wire logic [shb_pkg::COUNT_W-1:0]   wdata,
  input  wire logic                          re,
  input  wire logic [AW-1:0]                 raddr,
  output logic      [shb_pkg::COUNT_W-1:0]   rdata
);

  logic [shb_pkg::COUNT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/speed_histogram_binner.sv
// ----------------------------------------------------------------------------
// speed_histogram_binner
// Counts Q16.8 speed samples into saturating bin counters; reads one bin or
// clears all bins on command.
//
//   Port group         Direction   Transfer when
//   start/mode/...     in          start high and busy low at a clock edge
//   result_valid/...   out         result_valid high (one cycle, no stall)
//   APB psel/...       in/out      psel, penable, pwrite and pready high
//
// Add sample: busy while the bin engine runs and the counter is updated
// (the bin engine: three setup steps, seven multiply steps, seven divide
// steps, one finish; then the counter update). A sample below the range or
// an empty range ends the engine after the second setup step, and an
// overflowing sample after the third. The shared adder makes the steps serial.
// Read bin: the result is on the ports while busy is high in S_RDOUT.
// Clear all bins: busy while it clears one counter per cycle, 0 to MAX_BINS-1.
// After reset the same clearing pass runs with busy high.
// ----------------------------------------------------------------------------
`default_nettype none

module speed_histogram_binner #(
  parameter int MAX_BINS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [3:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [shb_pkg::MODE_W-1:0]    mode,
  input  wire logic [shb_pkg::SPEED_W-1:0]   speed,
  input  wire logic [shb_pkg::SEL_W-1:0]     bin_select,
  output logic                               result_valid,
  output logic      [shb_pkg::SEL_W-1:0]     read_bin,
  output logic      [shb_pkg::COUNT_W-1:0]   bin_count
);

  localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_BINS - 1);

  shb_pkg::cfg_t   cfg;
  shb_pkg::state_t state, state_next;

  logic [shb_pkg::NBIN_W-1:0]  nbins;
  logic                        calc_start;
  logic                        calc_done;
  logic [shb_pkg::NBIN_W-1:0]  calc_bin;

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [shb_pkg::COUNT_W-1:0] mem_wdata;
  logic                        mem_re;
  logic [AW-1:0]               mem_raddr;
  logic [shb_pkg::COUNT_W-1:0] mem_rdata;
  logic [shb_pkg::COUNT_W-1:0] count_inc;

  logic [AW-1:0]               clr_addr;
  logic [AW-1:0]               wr_addr;
  logic [shb_pkg::SEL_W-1:0]   sel_q;
  logic                        sel_ok;
  logic                        accept;

  shb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Out-of-range bin counts are pulled into 1..MAX_BINS.
  always_comb begin
    priority if (cfg.bins_in_use == '0) begin
      nbins = 7'd1;
    end else if (32'(cfg.bins_in_use) > 32'(MAX_BINS)) begin
      nbins = 7'(MAX_BINS);
    end else begin
      nbins = cfg.bins_in_use;
    end
  end

  shb_bin_calc u_calc (
    .clk       (clk),
    .rst       (rst),
    .start     (calc_start),
    .speed     (speed),
    .range_min (cfg.range_min),
    .range_max (cfg.range_max),
    .nbins     (nbins),
    .done      (calc_done),
    .bin       (calc_bin)
  );

  shb_mem #(
    .DEPTH (MAX_BINS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign busy   = (state != shb_pkg::S_IDLE);
  assign accept = start & ~busy;

  // Counters stick at all ones.
  assign count_inc = (mem_rdata == '1) ? mem_rdata : mem_rdata + 32'd1;

  always_comb begin
    state_next = state;
    calc_start = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = AW'(calc_bin);
    mem_we     = 1'b0;
    mem_waddr  = clr_addr;
    mem_wdata  = '0;
    unique case (state)
      shb_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr == LAST_ADDR) state_next = shb_pkg::S_IDLE;
      end
      shb_pkg::S_IDLE: begin
        mem_raddr = AW'(bin_select);
        if (accept) begin
          priority if (mode == shb_pkg::MODE_ADD) begin
            calc_start = 1'b1;
            state_next = shb_pkg::S_BIN;
          end else if (mode == shb_pkg::MODE_READ) begin
            mem_re     = 1'b1;
            state_next = shb_pkg::S_RDOUT;
          end else if (mode == shb_pkg::MODE_CLEAR) begin
            state_next = shb_pkg::S_CLEAR;
          end else begin
            state_next = shb_pkg::S_IDLE;
          end
        end
      end
      shb_pkg::S_BIN: begin
        if (calc_done) begin
          mem_re     = 1'b1;
          state_next = shb_pkg::S_INC;
        end
      end
      shb_pkg::S_INC: begin
        mem_we     = 1'b1;
        mem_waddr  = wr_addr;
        mem_wdata  = count_inc;
        state_next = shb_pkg::S_IDLE;
      end
      shb_pkg::S_RDOUT: begin
        state_next = shb_pkg::S_IDLE;
      end
      default: state_next = shb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= shb_pkg::S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == shb_pkg::S_CLEAR) clr_addr <= clr_addr + AW'(1);
      else clr_addr <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == shb_pkg::S_BIN && calc_done) wr_addr <= AW'(calc_bin);
    if (accept) begin
      sel_q  <= bin_select;
      sel_ok <= (32'(bin_select) < 32'(MAX_BINS));
    end
  end

  assign result_valid = (state == shb_pkg::S_RDOUT);
  assign read_bin     = sel_q;
  assign bin_count    = sel_ok ? mem_rdata : '0;

  a_read_gives_result: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == shb_pkg::MODE_READ) |=> result_valid)
    else $error("read transfer did not produce a result");

  a_other_no_result: assert property (@(posedge clk) disable iff (rst)
    (accept && mode != shb_pkg::MODE_READ) |=> !result_valid)
    else $error("result produced for a non-read transfer");

  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result strobe while the block is idle");

  a_calc_done_in_bin: assert property (@(posedge clk) disable iff (rst)
    calc_done |-> state == shb_pkg::S_BIN)
    else $error("bin engine finished outside a sample add");

endmodule

`default_nettype wire

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for speed_histogram_binner
// Feeds add, read, clear and unused commands through the start/busy port
// under several range and bin settings written over the APB-style port.
// A bit-exact model of the bin counters predicts every read, and each
// result strobe is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int NUM_BINS = 64;
  localparam int SETTLE = 80;
  localparam logic [shb_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [shb_pkg::MODE_W-1:0]  op;
    logic [shb_pkg::SPEED_W-1:0] spd;
    logic [shb_pkg::SEL_W-1:0]   sel;
  } bin_cmd_t;

  typedef struct {
    logic [shb_pkg::SEL_W-1:0]   num;
    logic [shb_pkg::COUNT_W-1:0] cnt;
  } bin_read_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic [shb_pkg::MODE_W-1:0] mode = shb_pkg::MODE_ADD;
  logic [shb_pkg::SPEED_W-1:0] speed = '0;
  logic [shb_pkg::SEL_W-1:0] bin_select = '0;
  logic result_valid;
  logic [shb_pkg::SEL_W-1:0] read_bin;
  logic [shb_pkg::COUNT_W-1:0] bin_count;

  speed_histogram_binner #(.MAX_BINS(NUM_BINS)) uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .mode(mode), .speed(speed), .bin_select(bin_select),
    .result_valid(result_valid), .read_bin(read_bin), .bin_count(bin_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Model copy of the configuration and the counter store.
  logic [shb_pkg::SPEED_W-1:0] cfg_min = shb_pkg::RANGE_MIN_RST;
  logic [shb_pkg::SPEED_W-1:0] cfg_max = shb_pkg::RANGE_MAX_RST;
  logic [shb_pkg::NBIN_W-1:0]  cfg_bins = shb_pkg::BINS_IN_USE_RST;
  logic [shb_pkg::COUNT_W-1:0] tally [NUM_BINS];

  bin_cmd_t  pending_cmds[$];
  bin_read_t expected_reads[$];
  bin_cmd_t  cur;
  logic      accepted = 1'b0;
  bit        gaps_on = 1'b1;
  int        idle_left = 0;
  int        errors = 0;

  initial begin
    foreach (tally[i]) tally[i] = '0;
  end

  function automatic int unsigned eff_bins();
    int unsigned n;
    n = 32'(cfg_bins);
    if (n < 1) n = 1;
    if (n > NUM_BINS) n = NUM_BINS;
    return n;
  endfunction

  function automatic int unsigned speed_to_bin(logic [shb_pkg::SPEED_W-1:0] s);
    int unsigned n;
    bit [63:0] num, den, q;
    n = eff_bins();
    if (cfg_max <= cfg_min) return n - 1;
    if (s < cfg_min) return 0;
    num = (64'(s) - 64'(cfg_min)) * 64'(n);
    den = 64'(cfg_max) - 64'(cfg_min);
    q = num / den;
    if (q >= 64'(n)) return n - 1;
    return 32'(q);
  endfunction

  function automatic void tally_command(bin_cmd_t c);
    int unsigned b;
    bin_read_t r;
    case (c.op)
      shb_pkg::MODE_ADD: begin
        b = speed_to_bin(c.spd);
        if (b < NUM_BINS && tally[b] != '1) tally[b] = tally[b] + 32'd1;
      end
      shb_pkg::MODE_READ: begin
        r.num = c.sel;
        r.cnt = (c.sel < NUM_BINS) ? tally[c.sel] : '0;
        expected_reads.push_back(r);
      end
      shb_pkg::MODE_CLEAR: begin
        foreach (tally[i]) tally[i] = '0;
      end
      default: ;
    endcase
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Driver: inputs change on the falling edge; a held command stays put
  // until the rising edge at which busy is low.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !accepted) begin
    end else begin
      if (start) idle_left = pick_gap();
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        cur = pending_cmds.pop_front();
        start <= 1'b1;
        mode <= cur.op;
        speed <= cur.spd;
        bin_select <= cur.sel;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks the result strobe, then records a command transfer.
  always @(posedge clk) begin
    bin_read_t e;
    accepted <= !rst && start && !busy;
    if (!rst && result_valid) begin
      if (expected_reads.size() == 0) begin
        flag_error($sformatf("unexpected result bin %0d count %0d", read_bin, bin_count));
      end else begin
        e = expected_reads.pop_front();
        if (read_bin !== e.num)
          flag_error($sformatf("read_bin %0d, expected %0d", read_bin, e.num));
        if (bin_count !== e.cnt)
          flag_error($sformatf("bin %0d: bin_count %0d, expected %0d",
                               e.num, bin_count, e.cnt));
      end
    end
    if (!rst && start && !busy) tally_command(cur);
  end

  task automatic queue_cmd(input logic [shb_pkg::MODE_W-1:0] op,
                           input logic [shb_pkg::SPEED_W-1:0] s,
                           input logic [shb_pkg::SEL_W-1:0] sel);
    bin_cmd_t c;
    c.op = op;
    c.spd = s;
    c.sel = sel;
    pending_cmds.push_back(c);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      shb_pkg::REG_RANGE_MIN:   cfg_min = data[shb_pkg::SPEED_W-1:0];
      shb_pkg::REG_RANGE_MAX:   cfg_max = data[shb_pkg::SPEED_W-1:0];
      shb_pkg::REG_BINS_IN_USE: cfg_bins = data[shb_pkg::NBIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_ranges(input logic [shb_pkg::SPEED_W-1:0] lo,
                            input logic [shb_pkg::SPEED_W-1:0] hi,
                            input logic [shb_pkg::NBIN_W-1:0] n);
    write_reg(shb_pkg::REG_RANGE_MIN, 32'(lo));
    write_reg(shb_pkg::REG_RANGE_MAX, 32'(hi));
    write_reg(shb_pkg::REG_BINS_IN_USE, 32'(n));
  endtask

  // Adds produce no result, so after the last read the block may still be
  // working; give it the clear-pass time before touching the registers.
  task automatic wait_idle();
    while (pending_cmds.size() != 0 || start || expected_reads.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic queue_random();
    int r, pick;
    int unsigned span, v;
    logic [shb_pkg::SPEED_W-1:0] s;
    logic [shb_pkg::SEL_W-1:0] sel;
    r = $urandom_range(0, 99);
    pick = $urandom_range(0, 99);
    span = (cfg_max > cfg_min) ? int'(cfg_max - cfg_min) : 0;
    if (pick < 60 && span != 0) begin
      v = int'(cfg_min) + $urandom_range(0, span + span / 4);
      s = (v > 32'hFF_FFFF) ? 24'hFF_FFFF : v[shb_pkg::SPEED_W-1:0];
    end else if (pick < 85) begin
      s = shb_pkg::SPEED_W'($urandom());
    end else begin
      case ($urandom_range(0, 5))
        0: s = cfg_min;
        1: s = cfg_max;
        2: s = cfg_min - 24'd1;
        3: s = cfg_max - 24'd1;
        4: s = '0;
        default: s = '1;
      endcase
    end
    if ($urandom_range(0, 3) != 0) sel = shb_pkg::SEL_W'($urandom_range(0, eff_bins() - 1));
    else sel = shb_pkg::SEL_W'($urandom());
    if (r < 70) queue_cmd(shb_pkg::MODE_ADD, s, sel);
    else if (r < 88) queue_cmd(shb_pkg::MODE_READ, s, sel);
    else if (r < 91) queue_cmd(shb_pkg::MODE_CLEAR, s, sel);
    else queue_cmd(MODE_UNUSED, s, sel);
  endtask

  initial begin
    logic [shb_pkg::SPEED_W-1:0] lo, hi;
    logic [shb_pkg::NBIN_W-1:0] n;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait_idle();

    // Default range: bin edges, overflow, the unused code, and a clear.
    queue_cmd(shb_pkg::MODE_ADD, 24'd0, '0);
    queue_cmd(shb_pkg::MODE_ADD, 24'd576, '0);
    queue_cmd(shb_pkg::MODE_ADD, 24'd11519, '0);
    queue_cmd(shb_pkg::MODE_ADD, 24'd11520, '0);
    queue_cmd(shb_pkg::MODE_ADD, 24'hFF_FFFF, '0);
    queue_cmd(MODE_UNUSED, 24'hFF_FFFF, 6'h3F);
    queue_cmd(shb_pkg::MODE_READ, '0, 6'd0);
    queue_cmd(shb_pkg::MODE_READ, '0, 6'd1);
    queue_cmd(shb_pkg::MODE_READ, '0, 6'd19);
    queue_cmd(shb_pkg::MODE_READ, '0, 6'd63);
    queue_cmd(shb_pkg::MODE_CLEAR, '0, '0);
    queue_cmd(shb_pkg::MODE_READ, '0, 6'd19);
    wait_idle();

    // Sample below the range and the range edges.
    set_ranges(24'd1000, 24'd2000, 7'd64);
    queue_cmd(shb_pkg::MODE_ADD, 24'd999, '0);
    queue_cmd(shb_pkg::MODE_ADD, 24'd1000, '0);
    queue_cmd(shb_pkg::MODE_ADD, 24'd1999, '0);
    queue_cmd(shb_pkg::MODE_READ, '0, 6'd0);
    queue_cmd(shb_pkg::MODE_READ, '0, 6'd63);
    wait_idle();

    // Inverted range with a bin count of zero, which acts as one bin.
    set_ranges(24'd5000, 24'd4000, 7'd0);
    queue_cmd(shb_pkg::MODE_ADD, 24'd0, '0);
    queue_cmd(shb_pkg::MODE_READ, '0, 6'd0);
    wait_idle();

    // Empty range at the top with a bin count above the store size.
    set_ranges(24'hFF_FFFF, 24'hFF_FFFF, 7'd127);
    queue_cmd(shb_pkg::MODE_ADD, 24'd123, '0);
    queue_cmd(shb_pkg::MODE_READ, '0, 6'd63);
    wait_idle();

    set_ranges(24'd0, 24'hFF_FFFF, 7'd1);
    queue_cmd(shb_pkg::MODE_ADD, 24'hFF_FFFE, '0);
    queue_cmd(shb_pkg::MODE_READ, '0, 6'd0);
    wait_idle();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin lo = '0; hi = '1; n = 7'd64; end
        1: begin lo = '0; hi = 24'd1; n = 7'd64; end
        2: begin lo = '1; hi = '0; n = 7'd2; end
        default: begin
          lo = shb_pkg::SPEED_W'($urandom_range(0, 30000));
          hi = lo + 24'($urandom_range(0, 40000));
          if ($urandom_range(0, 4) == 0) hi = shb_pkg::SPEED_W'($urandom());
          n = ($urandom_range(0, 3) == 0) ? shb_pkg::NBIN_W'($urandom_range(0, 127))
                                          : shb_pkg::NBIN_W'($urandom_range(1, 64));
        end
      endcase
      set_ranges(lo, hi, n);
      gaps_on = (p % 3 != 1);
      for (int k = 0; k < 150; k++) queue_random();
      wait_idle();
    end

    if (expected_reads.size() != 0)
      flag_error($sformatf("%0d reads never returned", expected_reads.size()));
    if (errors == 0) begin
      $display("speed_histogram_binner test passed");
    end else begin
      $display("speed_histogram_binner test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("speed_histogram_binner test failed");
    $finish;
  end

endmodule

### speed_histogram_binner.f
design/shb_pkg.sv
design/shb_cfg.sv
design/shb_bin_calc.sv
design/shb_mem.sv
design/speed_histogram_binner.sv
sim/tb.sv
